### design/spd_pkg.sv
package spd_pkg;

   // Byte codes and checksum seed of the bus protocol.
   localparam logic [7:0]  SYNC_BYTE = 8'hAA;
   localparam logic [6:0]  SUM_INIT  = 7'h7F;
   localparam logic [15:0] CMD_RESET = 16'h0100;

   // Header byte positions: eight field bytes, then the checksum byte.
   localparam logic [3:0]  HDR_SUM_POS     = 4'd8;
   // Header position value that marks the frame phase of a packet.
   localparam logic [3:0]  HDR_FRAME_PHASE = 4'd9;

   // Frame byte positions: four data bytes, the septet, then the checksum.
   localparam logic [2:0]  FRM_SEPTET_POS  = 3'd4;
   localparam logic [2:0]  FRM_SUM_POS     = 3'd5;

   typedef enum logic {
      KIND_HEADER = 1'b0,
      KIND_FRAME  = 1'b1
   } result_kind_type;

   typedef struct packed {
      result_kind_type result_kind;
      logic [15:0]     dest_addr;
      logic [15:0]     src_addr;
      logic [3:0]      proto_version;
      logic [15:0]     command_word;
      logic [6:0]      frame_count;
      logic [6:0]      frame_index;
      logic [31:0]     payload;
      logic            checksum_ok;
      logic            last_frame;
   } result_type;

endpackage

### design/spd_if.sv
interface spd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spd_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [15:0] dest_addr;
   logic [15:0] src_addr;
   logic [3:0]  proto_version;
   logic [15:0] command_word;
   logic [6:0]  frame_count;
   logic [6:0]  frame_index;
   logic [31:0] payload;
   logic        checksum_ok;
   logic        last_frame;

   modport source (
      output valid, output result_kind, output dest_addr, output src_addr,
      output proto_version, output command_word, output frame_count,
      output frame_index, output payload, output checksum_ok, output last_frame,
      input ready
   );
   modport sink (
      input valid, input result_kind, input dest_addr, input src_addr,
      input proto_version, input command_word, input frame_count,
      input frame_index, input payload, input checksum_ok, input last_frame,
      output ready
   );
endinterface

### design/spd_engine.sv
module spd_engine import spd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] accepted_command,
   output logic        emit,
   output result_type  result
);

   logic        in_packet_ff, in_packet_in;
   logic [3:0]  header_pos_ff, header_pos_in;
   logic [2:0]  frame_pos_ff, frame_pos_in;
   logic [6:0]  frame_counter_ff, frame_counter_in;
   logic [6:0]  running_sum_ff, running_sum_in;
   logic [15:0] dest_ff, dest_in;
   logic [15:0] src_ff, src_in;
   logic [3:0]  proto_ff, proto_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [6:0]  count_ff, count_in;
   logic [31:0] data_ff, data_in;
   logic [3:0]  septet_ff, septet_in;

   logic [6:0]  sum_next;
   logic        sum_match;
   logic        frames_on;
   logic        frame_last;
   logic [31:0] restored;

   assign sum_next   = running_sum_ff - rx_byte[6:0];
   // The whole byte is compared, so a checksum byte with its MSB set never matches.
   assign sum_match  = (rx_byte == {1'b0, running_sum_ff});
   assign frames_on  = sum_match && (cmd_ff == accepted_command) && (count_ff != 7'd0);
   assign frame_last = ({1'b0, frame_counter_ff} + 8'd1) >= {1'b0, count_ff};
   assign restored   = data_ff | {septet_ff[3], 7'd0, septet_ff[2], 7'd0,
                                  septet_ff[1], 7'd0, septet_ff[0], 7'd0};

   always_comb begin
      in_packet_in     = in_packet_ff;
      header_pos_in    = header_pos_ff;
      frame_pos_in     = frame_pos_ff;
      frame_counter_in = frame_counter_ff;
      running_sum_in   = running_sum_ff;
      dest_in          = dest_ff;
      src_in           = src_ff;
      proto_in         = proto_ff;
      cmd_in           = cmd_ff;
      count_in         = count_ff;
      data_in          = data_ff;
      septet_in        = septet_ff;
      emit             = 1'b0;

      result.result_kind   = KIND_HEADER;
      result.dest_addr     = dest_ff;
      result.src_addr      = src_ff;
      result.proto_version = proto_ff;
      result.command_word  = cmd_ff;
      result.frame_count   = count_ff;
      result.frame_index   = 7'd0;
      result.payload       = 32'd0;
      result.checksum_ok   = sum_match;
      result.last_frame    = 1'b0;

      if (rx_byte == SYNC_BYTE) begin
         // A sync byte restarts the packet wherever we are.
         in_packet_in     = 1'b1;
         header_pos_in    = 4'd0;
         frame_pos_in     = 3'd0;
         frame_counter_in = 7'd0;
         running_sum_in   = SUM_INIT;
      end else if (in_packet_ff) begin
         if (header_pos_ff < HDR_SUM_POS) begin
            case (header_pos_ff[2:0])
               3'd0:    dest_in[7:0]   = rx_byte;
               3'd1:    dest_in[15:8]  = rx_byte;
               3'd2:    src_in[7:0]    = rx_byte;
               3'd3:    src_in[15:8]   = rx_byte;
               3'd4:    proto_in       = rx_byte[7:4];
               3'd5:    cmd_in[7:0]    = rx_byte;
               3'd6:    cmd_in[15:8]   = rx_byte;
               default: count_in       = rx_byte[6:0];
            endcase
            running_sum_in = sum_next;
            header_pos_in  = header_pos_ff + 4'd1;
         end else if (header_pos_ff == HDR_SUM_POS) begin
            emit              = 1'b1;
            result.last_frame = !frames_on;
            if (frames_on) begin
               header_pos_in    = HDR_FRAME_PHASE;
               frame_pos_in     = 3'd0;
               frame_counter_in = 7'd0;
               running_sum_in   = SUM_INIT;
            end else begin
               in_packet_in = 1'b0;
            end
         end else begin
            case (frame_pos_ff)
               3'd0: begin
                  data_in[7:0]   = rx_byte;
                  running_sum_in = sum_next;
                  frame_pos_in   = 3'd1;
               end
               3'd1: begin
                  data_in[15:8]  = rx_byte;
                  running_sum_in = sum_next;
                  frame_pos_in   = 3'd2;
               end
               3'd2: begin
                  data_in[23:16] = rx_byte;
                  running_sum_in = sum_next;
                  frame_pos_in   = 3'd3;
               end
               3'd3: begin
                  data_in[31:24] = rx_byte;
                  running_sum_in = sum_next;
                  frame_pos_in   = FRM_SEPTET_POS;
               end
               FRM_SEPTET_POS: begin
                  // Only the low four septet bits carry data-byte MSBs.
                  septet_in      = rx_byte[3:0];
                  running_sum_in = sum_next;
                  frame_pos_in   = FRM_SUM_POS;
               end
               default: begin
                  emit               = 1'b1;
                  result.result_kind = KIND_FRAME;
                  result.frame_index = frame_counter_ff;
                  result.payload     = restored;
                  result.last_frame  = frame_last;
                  if (frame_last) begin
                     in_packet_in = 1'b0;
                  end else begin
                     frame_counter_in = frame_counter_ff + 7'd1;
                     frame_pos_in     = 3'd0;
                     running_sum_in   = SUM_INIT;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff     <= 1'b0;
         header_pos_ff    <= 4'd0;
         frame_pos_ff     <= 3'd0;
         frame_counter_ff <= 7'd0;
         running_sum_ff   <= SUM_INIT;
      end else if (step) begin
         in_packet_ff     <= in_packet_in;
         header_pos_ff    <= header_pos_in;
         frame_pos_ff     <= frame_pos_in;
         frame_counter_ff <= frame_counter_in;
         running_sum_ff   <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         dest_ff   <= dest_in;
         src_ff    <= src_in;
         proto_ff  <= proto_in;
         cmd_ff    <= cmd_in;
         count_ff  <= count_in;
         data_ff   <= data_in;
         septet_ff <= septet_in;
      end
   end

endmodule

### design/septet_packet_deframer.sv
// Channel  Direction  Payload                                      Handshake
// req      in         rx_byte (8)                                  valid / ready
// rsp      out        kind, addresses, version, command, counts,   valid / ready
//                     frame index, payload (32), checksum, last
// csr      in         csr_wr_data (16), accepted command word      csr_wr_en
//
// A byte beat is decoded while it sits in the input register, and its result
// is registered in the output register, where it stays until it is taken.
// One byte is accepted per cycle while results drain.
// Reset is synchronous and active high; it clears the packet tracking and
// loads the accepted command with 0x0100. A stalled result holds the output
// register, and the input register keeps taking bytes until it holds one that
// would produce a result.
module septet_packet_deframer import spd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   spd_req_if.sink       req,
   spd_rsp_if.source     rsp,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data
);

   // Command word whose data frames get decoded.
   logic [15:0] accepted_command_ff;

   // Input register: one received byte waiting to be decoded.
   logic        byte_valid_ff;
   logic [7:0]  byte_ff;

   // Output register: one finished result waiting for the sink.
   logic        rsp_valid_ff;
   result_type  result_ff;

   logic        emit;
   logic        out_free;
   logic        step;
   result_type  result;

   // The output register can take a new result when it is empty or being
   // drained in this same cycle.
   assign out_free = !rsp_valid_ff || rsp.ready;

   // The held byte is decoded when it produces no result, or when there is
   // room for the result it produces.
   assign step = byte_valid_ff && (!emit || out_free);

   // A new byte enters whenever the input register is empty or moves on.
   assign req.ready = !byte_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_command_ff <= CMD_RESET;
      end else if (csr_wr_en) begin
         accepted_command_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (req.ready) begin
         byte_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         byte_ff <= req.rx_byte;
      end
   end

   spd_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .rx_byte          (byte_ff),
      .accepted_command (accepted_command_ff),
      .emit             (emit),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && step && emit) begin
         result_ff <= result;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.result_kind   = result_ff.result_kind;
   assign rsp.dest_addr     = result_ff.dest_addr;
   assign rsp.src_addr      = result_ff.src_addr;
   assign rsp.proto_version = result_ff.proto_version;
   assign rsp.command_word  = result_ff.command_word;
   assign rsp.frame_count   = result_ff.frame_count;
   assign rsp.frame_index   = result_ff.frame_index;
   assign rsp.payload       = result_ff.payload;
   assign rsp.checksum_ok   = result_ff.checksum_ok;
   assign rsp.last_frame    = result_ff.last_frame;

endmodule
